[hw/rtl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared types and constants for the HSV to RGB color converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Width of one output color channel.
    localparam int unsigned CHAN_BITS = 8;

    // Hue sector: which sixth of the color wheel the hue falls into.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

endpackage

[hw/rtl/hsv_to_rgb_converter_unit.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Streaming six-sector conversion of hue, saturation and value to 8-bit RGB.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock while the output side does not
// stall, and returns one RGB transaction for each input transaction, in
// order. The pipeline has five register stages: hue sector split and
// clamping, the saturation times value multiply, the chroma times
// sector-position multiply, the per-channel component selection and offset
// add, and the scaling to 0..255 held in the output register. Back-pressure
// from the output travels back through the stages, and an empty stage is
// always filled, so bubbles close up and no transaction is lost or repeated.
// Saturation and value above one clamp to one; the hue is a fraction of a
// full turn and wraps.

module hsv_to_rgb_converter_unit #(
    parameter int unsigned FRAC_BITS = 12,
    parameter int unsigned HUE_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Input stream. tdata from bit 0 up: hue_turn (HUE_BITS bits),
    // saturation (FRAC_BITS+1 bits), brightness (FRAC_BITS+1 bits), zero pad.
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  logic [((HUE_BITS+2*(FRAC_BITS+1)+7)/8)*8-1:0] i_s_axis_tdata,

    // Output stream. tdata from bit 0 up: red, green, blue (8 bits each).
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    output logic [3*hsv2rgb_pkg::CHAN_BITS-1:0]         o_m_axis_tdata
);

    localparam int unsigned SAT_W = FRAC_BITS + 1;        // Q1.FRAC_BITS field
    localparam int unsigned SV_W  = 2 * FRAC_BITS + 1;    // saturation * value
    localparam int unsigned WGT_W = HUE_BITS + 1;         // sector weight
    localparam int unsigned DEN   = 2 * FRAC_BITS + HUE_BITS;
    localparam int unsigned NUM_W = DEN + 1;              // exact channel numerator
    localparam int unsigned CB    = hsv2rgb_pkg::CHAN_BITS;

    // ------------------------------------------------------------------
    // Stage enables. A stage loads when it is empty or when its content
    // moves on to the next stage in the same clock.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || i_m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp saturation and value, split hue * 6 into the sector
    // number and the position inside the sector. Odd sectors count the
    // position down from the sector's end.
    // ------------------------------------------------------------------
    logic [HUE_BITS-1:0]   in_hue;
    logic [SAT_W-1:0]      in_sat;
    logic [SAT_W-1:0]      in_val;
    logic [HUE_BITS+2:0]   h6;
    logic [HUE_BITS-1:0]   pos;
    logic [SAT_W-1:0]      n_sat1;
    logic [SAT_W-1:0]      n_val1;
    logic [WGT_W-1:0]      n_wgt1;
    hsv2rgb_pkg::t_sector  n_sec1;

    localparam logic [SAT_W-1:0] ONE_Q = SAT_W'(1) << FRAC_BITS;

    assign in_hue = i_s_axis_tdata[HUE_BITS-1:0];
    assign in_sat = i_s_axis_tdata[HUE_BITS+SAT_W-1:HUE_BITS];
    assign in_val = i_s_axis_tdata[HUE_BITS+2*SAT_W-1:HUE_BITS+SAT_W];

    always_comb begin
        h6     = ({3'b000, in_hue} << 2) + ({3'b000, in_hue} << 1);
        pos    = h6[HUE_BITS-1:0];
        n_sec1 = hsv2rgb_pkg::t_sector'(h6[HUE_BITS+2:HUE_BITS]);
        if (h6[HUE_BITS]) begin
            n_wgt1 = (WGT_W'(1) << HUE_BITS) - {1'b0, pos};
        end else begin
            n_wgt1 = {1'b0, pos};
        end
        n_sat1 = (in_sat > ONE_Q) ? ONE_Q : in_sat;
        n_val1 = (in_val > ONE_Q) ? ONE_Q : in_val;
    end

    logic [SAT_W-1:0]     r_sat1;
    logic [SAT_W-1:0]     r_val1;
    logic [WGT_W-1:0]     r_wgt1;
    hsv2rgb_pkg::t_sector r_sec1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_sat1 <= n_sat1;
            r_val1 <= n_val1;
            r_wgt1 <= n_wgt1;
            r_sec1 <= n_sec1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: chroma numerator, saturation times value.
    // ------------------------------------------------------------------
    logic [2*SAT_W-1:0]   sv_full;
    logic [SV_W-1:0]      r_sv2;
    logic [SAT_W-1:0]     r_val2;
    logic [WGT_W-1:0]     r_wgt2;
    hsv2rgb_pkg::t_sector r_sec2;

    assign sv_full = r_sat1 * r_val1;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_sv2  <= sv_full[SV_W-1:0];
            r_val2 <= r_val1;
            r_wgt2 <= r_wgt1;
            r_sec2 <= r_sec1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: secondary component and offset. The offset is held without
    // its trailing HUE_BITS zeros, as is the chroma.
    // ------------------------------------------------------------------
    logic [SV_W+WGT_W-1:0] x_full;
    logic [SV_W-1:0]       n_m3;
    logic [NUM_W-1:0]      r_x3;
    logic [SV_W-1:0]       r_c3;
    logic [SV_W-1:0]       r_m3;
    hsv2rgb_pkg::t_sector  r_sec3;

    assign x_full = r_sv2 * r_wgt2;
    assign n_m3   = ({{FRAC_BITS{1'b0}}, r_val2} << FRAC_BITS) - r_sv2;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_x3   <= x_full[NUM_W-1:0];
            r_c3   <= r_sv2;
            r_m3   <= n_m3;
            r_sec3 <= r_sec2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: route chroma and secondary component to the channels for
    // this sector and add the offset. Each sum is at most 2^DEN.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] c_full;
    logic [NUM_W-1:0] m_full;
    logic [NUM_W-1:0] zero_n;
    logic [NUM_W-1:0] sel_r, sel_g, sel_b;
    logic [NUM_W-1:0] r_nr4, r_ng4, r_nb4;

    assign c_full = {r_c3, {HUE_BITS{1'b0}}};
    assign m_full = {r_m3, {HUE_BITS{1'b0}}};
    assign zero_n = '0;

    always_comb begin
        case (r_sec3)
            hsv2rgb_pkg::SEC_RED_YELLOW: begin
                sel_r = c_full; sel_g = r_x3;   sel_b = zero_n;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
                sel_r = r_x3;   sel_g = c_full; sel_b = zero_n;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN: begin
                sel_r = zero_n; sel_g = c_full; sel_b = r_x3;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE: begin
                sel_r = zero_n; sel_g = r_x3;   sel_b = c_full;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
                sel_r = r_x3;   sel_g = zero_n; sel_b = c_full;
            end
            default: begin
                sel_r = c_full; sel_g = zero_n; sel_b = r_x3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_nr4 <= sel_r + m_full;
            r_ng4 <= sel_g + m_full;
            r_nb4 <= sel_b + m_full;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale by 255 as (n << 8) - n and keep the integer part.
    // ------------------------------------------------------------------
    logic [NUM_W+CB-1:0] s_r, s_g, s_b;
    logic [3*CB-1:0]     r_rgb5;

    assign s_r = {r_nr4, {CB{1'b0}}} - {{CB{1'b0}}, r_nr4};
    assign s_g = {r_ng4, {CB{1'b0}}} - {{CB{1'b0}}, r_ng4};
    assign s_b = {r_nb4, {CB{1'b0}}} - {{CB{1'b0}}, r_nb4};

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_rgb5 <= {s_b[DEN+CB-1:DEN], s_g[DEN+CB-1:DEN], s_r[DEN+CB-1:DEN]};
        end
    end

    assign o_m_axis_tdata = r_rgb5;

endmodule

[verif/hsv_to_rgb_converter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter unit testbench
// Drives hue, saturation and value transactions into the unit and compares
// every RGB transaction with a bit-exact fixed-point prediction, under random
// idling on both streams and a long output hold-off.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_unit_tb;

    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned HUE_BITS  = 16;
    localparam int unsigned IN_BITS   = ((HUE_BITS + 2 * (FRAC_BITS + 1) + 7) / 8) * 8;
    localparam int unsigned OUT_BITS  = 3 * hsv2rgb_pkg::CHAN_BITS;
    // Common denominator exponent of chroma, secondary and offset terms.
    localparam int unsigned DEN_SHIFT = 2 * FRAC_BITS + HUE_BITS;
    localparam logic [63:0] UNIT_Q    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FULL_TURN = 64'd1 << HUE_BITS;
    // One and one step in the width of the saturation and value fields.
    localparam logic [FRAC_BITS:0] FIELD_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] FIELD_LSB = {{FRAC_BITS{1'b0}}, 1'b1};

    localparam int unsigned IDLE_PCT       = 36;
    localparam int unsigned HOLD_OFF_LEN   = 300;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RANDOM_IDLING  = 700;
    localparam int unsigned RANDOM_STEADY  = 266;

    typedef struct packed {
        logic [hsv2rgb_pkg::CHAN_BITS-1:0] blue;
        logic [hsv2rgb_pkg::CHAN_BITS-1:0] green;
        logic [hsv2rgb_pkg::CHAN_BITS-1:0] red;
    } t_rgb_pixel;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // From bit 0 up: hue_turn, saturation, brightness, zero pad.
    logic [IN_BITS-1:0]  i_s_axis_tdata  = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // From bit 0 up: red, green, blue.
    logic [OUT_BITS-1:0] o_m_axis_tdata;

    // Pixels accepted by the unit whose RGB transaction has not come back yet.
    t_rgb_pixel expected_rgb_q[$];

    int unsigned error_count     = 0;
    int unsigned pixels_sent     = 0;
    int unsigned pixels_checked  = 0;
    int unsigned clamped_pixels  = 0;
    int unsigned sector_hits[6]  = '{default: 0};
    int unsigned quiet_cycles    = 0;

    // Random idling switches for each side, and the hold-off request that the
    // output process turns into a stall of its own counted length.
    bit          src_idle_en     = 1'b1;
    bit          sink_idle_en    = 1'b1;
    int unsigned hold_off_req    = 0;
    int unsigned hold_off_left   = 0;

    hsv_to_rgb_converter_unit #(
        .FRAC_BITS (FRAC_BITS),
        .HUE_BITS  (HUE_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scales an exact numerator over 2^DEN_SHIFT to 0..255, truncating.
    function automatic logic [hsv2rgb_pkg::CHAN_BITS-1:0] scale_channel(
        input logic [63:0] numer);
        logic [63:0] scaled;
        scaled = numer * 64'd255;
        return scaled[DEN_SHIFT +: hsv2rgb_pkg::CHAN_BITS];
    endfunction

    function automatic hsv2rgb_pkg::t_sector hue_sector(input logic [HUE_BITS-1:0] hue);
        logic [63:0] h6;
        h6 = 64'(hue) * 64'd6;
        return hsv2rgb_pkg::t_sector'(h6[HUE_BITS +: 3]);
    endfunction

    // Six-sector conversion with all terms held exactly, so the only rounding
    // is the final truncation of each channel.
    function automatic t_rgb_pixel convert_hsv(input logic [HUE_BITS-1:0]  hue,
                                               input logic [FRAC_BITS:0]   sat_in,
                                               input logic [FRAC_BITS:0]   val_in);
        logic [63:0] sat, val, h6, pos, weight, sv, chroma, second, offset;
        logic [63:0] r_n, g_n, b_n;
        hsv2rgb_pkg::t_sector sector;
        t_rgb_pixel  pix;
        sat    = (64'(sat_in) > UNIT_Q) ? UNIT_Q : 64'(sat_in);
        val    = (64'(val_in) > UNIT_Q) ? UNIT_Q : 64'(val_in);
        h6     = 64'(hue) * 64'd6;
        sector = hue_sector(hue);
        pos    = h6 & (FULL_TURN - 64'd1);
        // Odd sectors fall from full weight, even sectors rise toward it.
        weight = h6[HUE_BITS] ? (FULL_TURN - pos) : pos;
        sv     = sat * val;
        chroma = sv << HUE_BITS;
        second = sv * weight;
        offset = (val << (FRAC_BITS + HUE_BITS)) - chroma;
        case (sector)
            hsv2rgb_pkg::SEC_RED_YELLOW: begin
                r_n = chroma; g_n = second; b_n = '0;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
                r_n = second; g_n = chroma; b_n = '0;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN: begin
                r_n = '0; g_n = chroma; b_n = second;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE: begin
                r_n = '0; g_n = second; b_n = chroma;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
                r_n = second; g_n = '0; b_n = chroma;
            end
            default: begin
                r_n = chroma; g_n = '0; b_n = second;
            end
        endcase
        pix.red   = scale_channel(r_n + offset);
        pix.green = scale_channel(g_n + offset);
        pix.blue  = scale_channel(b_n + offset);
        return pix;
    endfunction

    // Offers one pixel, idling first at random, and records the expected color
    // once the unit has taken the transaction. The valid stays high on return
    // so back-to-back pixels need no gap.
    task automatic send_pixel(input logic [HUE_BITS-1:0] hue,
                              input logic [FRAC_BITS:0]  sat,
                              input logic [FRAC_BITS:0]  val);
        while (src_idle_en && $urandom_range(99, 0) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_BITS'({val, sat, hue});
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_rgb_q.push_back(convert_hsv(hue, sat, val));
        pixels_sent++;
        sector_hits[hue_sector(hue)]++;
        if (sat > UNIT_Q || val > UNIT_Q) begin
            clamped_pixels++;
        end
    endtask

    // Stops offering the last pixel again and waits until every expected
    // color has come back.
    task automatic wait_for_results;
        i_s_axis_tvalid <= 1'b0;
        while (expected_rgb_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Saturation or value drawn mostly from the legal 0..1 range, sometimes
    // from the whole field so the clamp and every upper bit get exercised.
    function automatic logic [FRAC_BITS:0] rand_unit_q;
        if ($urandom_range(99, 0) < 80) begin
            return (FRAC_BITS + 1)'($urandom_range(32'(UNIT_Q), 0));
        end
        return (FRAC_BITS + 1)'($urandom);
    endfunction

    // Full saturation and value at both sides of every sector boundary, so each
    // channel passes through its rising, flat and falling stretches.
    task automatic test_sector_edges;
        logic [HUE_BITS-1:0] edge_hue;
        for (int k = 0; k < 6; k++) begin
            edge_hue = HUE_BITS'((64'(k) * FULL_TURN + 64'd5) / 64'd6);
            if (k != 0) begin
                send_pixel(edge_hue - 1'b1, FIELD_ONE, FIELD_ONE);
            end
            send_pixel(edge_hue, FIELD_ONE, FIELD_ONE);
        end
        send_pixel('1, FIELD_ONE, FIELD_ONE);
        wait_for_results();
    endtask

    // Gray, black, white and dim corners of the field ranges.
    task automatic test_field_extremes;
        send_pixel('0, '0, '0);
        send_pixel('1, '0, FIELD_ONE);
        send_pixel(HUE_BITS'(21845), FIELD_ONE, '0);
        send_pixel(HUE_BITS'(43690), FIELD_LSB, FIELD_LSB);
        send_pixel(HUE_BITS'(12345), FIELD_ONE, FIELD_LSB);
        send_pixel(HUE_BITS'(54321), FIELD_LSB, FIELD_ONE);
        send_pixel(HUE_BITS'(32768), FIELD_ONE - FIELD_LSB, FIELD_ONE - FIELD_LSB);
        wait_for_results();
    endtask

    // Saturation and value above one must behave exactly like one.
    task automatic test_clamping;
        send_pixel(HUE_BITS'(5000), FIELD_ONE + FIELD_LSB, FIELD_ONE);
        send_pixel(HUE_BITS'(27000), FIELD_ONE, FIELD_ONE + FIELD_LSB);
        send_pixel(HUE_BITS'(40000), '1, '1);
        send_pixel(HUE_BITS'(60000), '1, (FRAC_BITS + 1)'(2048));
        send_pixel(HUE_BITS'(15000), (FRAC_BITS + 1)'(1000), '1);
        wait_for_results();
    endtask

    // The output holds off for a long stretch while pixels keep coming, so the
    // pipeline fills and the input side must stall without losing anything.
    task automatic test_backpressure;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_off_req = HOLD_OFF_LEN;
        for (int n = 0; n < 60; n++) begin
            send_pixel(HUE_BITS'($urandom), rand_unit_q(), rand_unit_q());
        end
        wait_for_results();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Random pixels, first with idling on both sides, then a steady stretch
    // where both streams run at full rate.
    task automatic test_random_pixels;
        for (int n = 0; n < RANDOM_IDLING; n++) begin
            send_pixel(HUE_BITS'($urandom), rand_unit_q(), rand_unit_q());
        end
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int n = 0; n < RANDOM_STEADY; n++) begin
            send_pixel(HUE_BITS'($urandom), rand_unit_q(), rand_unit_q());
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Output ready: low in reset and during a requested hold-off, random while
    // idling is enabled, otherwise always high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left   <= hold_off_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_off_req != 0) begin
            hold_off_left   <= hold_off_req - 1;
            hold_off_req    = 0;
            i_m_axis_tready <= 1'b0;
        end else if (sink_idle_en) begin
            i_m_axis_tready <= ($urandom_range(99, 0) >= IDLE_PCT);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Every RGB transaction is compared channel by channel with the oldest
    // expected color.
    always @(posedge i_clk) begin
        t_rgb_pixel got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_rgb_pixel'(o_m_axis_tdata);
            if (expected_rgb_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, actual r=%0d g=%0d b=%0d",
                         $time, got.red, got.green, got.blue);
            end else begin
                want = expected_rgb_q.pop_front();
                pixels_checked++;
                if (got.red !== want.red) begin
                    error_count++;
                    $display("%0t: red mismatch, expected %0d actual %0d",
                             $time, want.red, got.red);
                end
                if (got.green !== want.green) begin
                    error_count++;
                    $display("%0t: green mismatch, expected %0d actual %0d",
                             $time, want.green, got.green);
                end
                if (got.blue !== want.blue) begin
                    error_count++;
                    $display("%0t: blue mismatch, expected %0d actual %0d",
                             $time, want.blue, got.blue);
                end
            end
        end
    end

    // A run that stops moving on both streams for too long is a hang.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sector_edges();
        test_field_extremes();
        test_clamping();
        test_backpressure();
        test_random_pixels();

        i_s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_rgb_q.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected colors never arrived", $time, expected_rgb_q.size());
        end
        $display("Converted %0d pixels, %0d checked, %0d with clamped saturation or value.",
                 pixels_sent, pixels_checked, clamped_pixels);
        $display("Pixels per hue sector: %0d %0d %0d %0d %0d %0d",
                 sector_hits[0], sector_hits[1], sector_hits[2],
                 sector_hits[3], sector_hits[4], sector_hits[5]);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
